>>> design/fccr_pkg.sv
package fccr_pkg;

    // Longest read handled in one request; longer lengths are clipped to this.
    localparam int MAX_READ_BYTES = 16384;

    localparam int LEN_W     = 15;
    localparam int POS_W     = 36;
    localparam int SHIFT_W   = 5;   // log2 of cluster bytes, at most 19
    localparam int CB_W      = 20;  // cluster size in bytes
    localparam int WITHIN_W  = 19;  // offset inside a cluster
    localparam int AHEAD_W   = 23;  // 32-bit offset over the smallest cluster
    localparam int SECTOR_W  = 24;
    localparam int DSS_W     = 22;

    localparam logic [3:0] LBPS_MIN = 4'd9;
    localparam logic [3:0] LBPS_MAX = 4'd12;

    localparam logic [15:0] FAT_FIRST_DATA = 16'h0002;
    localparam logic [15:0] FAT_RSVD_MIN   = 16'hFFF0;
    localparam logic [15:0] FAT_BAD        = 16'hFFF7;
    localparam logic [15:0] FAT_END_MIN    = 16'hFFF8;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_END  = 2'd1,
        ST_BAD  = 2'd2,
        ST_FREE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_LBPS = 2'd0,
        CFG_LSPC = 2'd1,
        CFG_DSS  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_NEXT,
        S_SECTOR,
        S_EMIT,
        S_ERR
    } seq_state_t;

    typedef struct packed {
        logic [3:0]       lbps;   // already clamped to 9..12
        logic [2:0]       lspc;
        logic [DSS_W-1:0] dss;
    } cfg_t;

    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        logic [15:0] wdata;
        logic        re;
        logic [15:0] raddr;
    } tbl_req_t;

    function automatic status_t classify(input logic [15:0] v);
        status_t st;
        if (v < FAT_FIRST_DATA)
            st = ST_FREE;
        else if (v >= FAT_END_MIN)
            st = ST_END;
        else if (v == FAT_BAD)
            st = ST_BAD;
        else if (v >= FAT_RSVD_MIN)
            st = ST_FREE;
        else
            st = ST_OK;
        return st;
    endfunction

endpackage

>>> design/fccr_ifs.sv
interface fccr_in_if import fccr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [15:0]       fat_index;
    logic [15:0]       fat_value;
    logic [15:0]       start_cluster;
    logic [31:0]       file_offset;
    logic [LEN_W-1:0]  read_length;

    modport source (output valid, cmd, fat_index, fat_value, start_cluster, file_offset,
                    read_length, input ready);
    modport sink   (input valid, cmd, fat_index, fat_value, start_cluster, file_offset,
                    read_length, output ready);
endinterface

interface fccr_out_if import fccr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  disk_byte_pos;
    logic [LEN_W-1:0]  segment_length;
    logic              last;
    logic [1:0]        status;

    modport source (output valid, disk_byte_pos, segment_length, last, status, input ready);
    modport sink   (input valid, disk_byte_pos, segment_length, last, status, output ready);
endinterface

interface fccr_cfg_if import fccr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [DSS_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/fat16_cluster_chain_resolver.sv
// Channel   Dir  Beat contents
// req       in   cmd, fat_index, fat_value, start_cluster, file_offset, read_length
// rsp       out  disk_byte_pos, segment_length, last, status
// cfg       in   index, data (write to log2 sector size, log2 sectors per cluster, data start)
//
// A table load is a single write. A resolve checks the start cluster, then does one
// table read per cluster skipped to reach the offset and per link followed between
// segments, a sector add and an emit per segment, and a stop beat if the walk stops.
// Reset restores the configuration defaults and idles the sequencer; the table
// holds whatever was last written and has no clearing pass.
// A stalled rsp holds the sequencer in emit or on the stop beat; req is taken only
// between items.
module fat16_cluster_chain_resolver import fccr_pkg::*; #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    fccr_in_if.sink     req,
    fccr_out_if.source  rsp,
    fccr_cfg_if.sink    cfg
);

    cfg_t        cfg_q;
    tbl_req_t    tbl_req;
    logic [15:0] tbl_rdata;

    fccr_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    fccr_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .tbl_req (tbl_req),
        .rdata   (tbl_rdata)
    );

    fccr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_q     (cfg_q),
        .tbl_req   (tbl_req),
        .tbl_rdata (tbl_rdata)
    );

endmodule

>>> design/fccr_cfg.sv
module fccr_cfg import fccr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    fccr_cfg_if.sink   cfg,
    output cfg_t       cfg_q
);

    logic [3:0]       lbps_reg;
    logic [2:0]       lspc_reg;
    logic [DSS_W-1:0] dss_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lbps_reg <= 4'd9;
            lspc_reg <= 3'd2;
            dss_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_LBPS: lbps_reg <= cfg.data[3:0];
                CFG_LSPC: lspc_reg <= cfg.data[2:0];
                CFG_DSS:  dss_reg  <= cfg.data;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        if (lbps_reg < LBPS_MIN)
            cfg_q.lbps = LBPS_MIN;
        else if (lbps_reg > LBPS_MAX)
            cfg_q.lbps = LBPS_MAX;
        else
            cfg_q.lbps = lbps_reg;
        cfg_q.lspc = lspc_reg;
        cfg_q.dss  = dss_reg;
    end

endmodule

>>> design/fccr_table.sv
module fccr_table import fccr_pkg::*; #(
    parameter int ENTRIES = 65536
) (
    input  logic        clk,
    input  tbl_req_t    tbl_req,
    output logic [15:0] rdata
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [15:0] mem [ENTRIES];
    logic [15:0] rd_reg;
    logic        oob_reg;
    logic        w_in_range;
    logic        r_in_range;

    assign w_in_range = 17'(tbl_req.waddr) < 17'(ENTRIES);
    assign r_in_range = 17'(tbl_req.raddr) < 17'(ENTRIES);

    always_ff @(posedge clk)
    begin
        if (tbl_req.we && w_in_range)
            mem[tbl_req.waddr[IDX_W-1:0]] <= tbl_req.wdata;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_req.re)
        begin
            rd_reg  <= mem[tbl_req.raddr[IDX_W-1:0]];
            oob_reg <= !r_in_range;
        end
    end

    // entries past the table read as free
    assign rdata = oob_reg ? 16'h0000 : rd_reg;

endmodule

>>> design/fccr_seq.sv
module fccr_seq import fccr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    fccr_in_if.sink     req,
    fccr_out_if.source  rsp,
    input  cfg_t        cfg_q,
    output tbl_req_t    tbl_req,
    input  logic [15:0] tbl_rdata
);

    seq_state_t state_reg, state_next;

    logic [15:0]         cur_reg, cur_next;
    logic [WITHIN_W-1:0] within_reg, within_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [AHEAD_W-1:0]  ahead_reg, ahead_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    status_t             err_reg, err_next;

    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                last_reg, last_next;
    status_t             status_reg, status_next;

    logic [SHIFT_W-1:0]  shift;
    logic [CB_W-1:0]     cb;
    logic [CB_W-1:0]     cb_mask;
    logic [CB_W-1:0]     seg_room;
    logic [LEN_W-1:0]    seg;
    logic [LEN_W-1:0]    rem_left;
    logic [LEN_W-1:0]    len_sat;
    logic [POS_W-1:0]    pos;
    logic                out_free;
    logic                out_load;
    logic                in_beat;
    status_t             st_cur;
    status_t             st_rd;

    assign shift    = SHIFT_W'(cfg_q.lbps) + SHIFT_W'(cfg_q.lspc);
    assign cb       = CB_W'(1) << shift;
    assign cb_mask  = cb - CB_W'(1);
    assign seg_room = cb - CB_W'(within_reg);
    assign seg      = (seg_room > CB_W'(rem_reg)) ? rem_reg : seg_room[LEN_W-1:0];
    assign rem_left = rem_reg - seg;
    assign pos      = (POS_W'(sector_reg) << cfg_q.lbps) + POS_W'(within_reg);
    assign len_sat  = (17'(req.read_length) > 17'(MAX_READ_BYTES)) ?
                      LEN_W'(MAX_READ_BYTES) : req.read_length;
    assign out_free = !out_valid_reg || rsp.ready;
    assign in_beat  = req.valid && req.ready;
    assign st_cur   = classify(cur_reg);
    assign st_rd    = classify(tbl_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        within_reg <= within_next;
        rem_reg    <= rem_next;
        ahead_reg  <= ahead_next;
        sector_reg <= sector_next;
        err_reg    <= err_next;
        pos_reg    <= pos_next;
        len_reg    <= len_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        within_next = within_reg;
        rem_next    = rem_reg;
        ahead_next  = ahead_reg;
        sector_next = sector_reg;
        err_next    = err_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        last_next   = last_reg;
        status_next = status_reg;
        out_load    = 1'b0;
        req.ready   = 1'b0;
        tbl_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (in_beat)
                begin
                    if (req.cmd == CMD_LOAD)
                    begin
                        // table is only written between walks, so no read can collide
                        tbl_req.we    = 1'b1;
                        tbl_req.waddr = req.fat_index;
                        tbl_req.wdata = req.fat_value;
                    end
                    else
                    begin
                        cur_next    = req.start_cluster;
                        rem_next    = len_sat;
                        ahead_next  = AHEAD_W'(req.file_offset >> shift);
                        within_next = req.file_offset[WITHIN_W-1:0] & cb_mask[WITHIN_W-1:0];
                        state_next  = S_START;
                    end
                end
            end
            S_START:
            begin
                if (st_cur != ST_OK)
                begin
                    err_next   = st_cur;
                    state_next = S_ERR;
                end
                else if (ahead_reg != '0)
                begin
                    tbl_req.re    = 1'b1;
                    tbl_req.raddr = cur_reg;
                    state_next    = S_NEXT;
                end
                else
                begin
                    state_next = S_SECTOR;
                end
            end
            S_NEXT:
            begin
                if (st_rd != ST_OK)
                begin
                    err_next   = st_rd;
                    state_next = S_ERR;
                end
                else
                begin
                    cur_next = tbl_rdata;
                    if (ahead_reg != '0)
                    begin
                        ahead_next = ahead_reg - AHEAD_W'(1);
                        if (ahead_reg != AHEAD_W'(1))
                        begin
                            // follow the link straight from the read data
                            tbl_req.re    = 1'b1;
                            tbl_req.raddr = tbl_rdata;
                        end
                        else
                        begin
                            state_next = S_SECTOR;
                        end
                    end
                    else
                    begin
                        state_next = S_SECTOR;
                    end
                end
            end
            S_SECTOR:
            begin
                sector_next = SECTOR_W'(cfg_q.dss)
                            + SECTOR_W'(23'(cur_reg - FAT_FIRST_DATA) << cfg_q.lspc);
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    pos_next    = pos;
                    len_next    = seg;
                    last_next   = (rem_left == '0);
                    status_next = ST_OK;
                    rem_next    = rem_left;
                    if (rem_left == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tbl_req.re    = 1'b1;
                        tbl_req.raddr = cur_reg;
                        within_next   = '0;
                        state_next    = S_NEXT;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    pos_next    = '0;
                    len_next    = '0;
                    last_next   = 1'b1;
                    status_next = err_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.disk_byte_pos  = pos_reg;
    assign rsp.segment_length = len_reg;
    assign rsp.last           = last_reg;
    assign rsp.status         = status_reg;

`ifndef SYNTHESIS
    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_req.we |-> state_reg == S_IDLE)
        else $error("table write outside idle");

    a_walk_done_before_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> ahead_reg == '0)
        else $error("segment emitted before chain walk finished");

    a_within_in_cluster: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> CB_W'(within_reg) < cb)
        else $error("segment start outside cluster");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> state_reg == S_IDLE)
        else $error("sequencer busy after last beat");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> 17'(rem_reg) <= 17'(MAX_READ_BYTES))
        else $error("remaining length above limit");
`endif

endmodule
